FILE: rtl/cmbc_pkg.sv
// shared types and constants for the cartridge memory bank controller
// no dependencies; imported by cmbc_rom_map and the top level
package cmbc_pkg;

	// default sizes
	localparam int CART_RAM_BYTES_DEF    = 131072;
	localparam int CYCLES_PER_SECOND_DEF = 4194304;
	localparam int ROM_BANKS_MAX_DEF     = 512;
	localparam int NIBBLE_RAM_DEPTH      = 512;
	localparam int NIB_AW                = $clog2(NIBBLE_RAM_DEPTH);

	// mapper kinds
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_MBC1 = 3'd1;
	localparam logic [2:0] KIND_MBC2 = 3'd2;
	localparam logic [2:0] KIND_MBC3 = 3'd3;
	localparam logic [2:0] KIND_MBC5 = 3'd4;

	// actions
	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// data sources
	localparam logic [1:0] SRC_DATA = 2'd0;
	localparam logic [1:0] SRC_ROM  = 2'd1;
	localparam logic [1:0] SRC_NONE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_MAPPER_KIND    = 2'd0;
	localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd1;
	localparam logic [1:0] CFG_RAM_SIZE_BYTES = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [15:0] tick_cycles;
	} req_t;

	typedef struct packed {
		logic [1:0]  data_source;
		logic [7:0]  read_data;
		logic [22:0] rom_address;
	} rsp_t;

	// bank state seen by the rom mapper
	typedef struct packed {
		logic [2:0] kind;
		logic [9:0] bank_count;
		logic [7:0] low_bank;
		logic [7:0] high_bank;
		logic       bank_mode;
		logic [8:0] wide_bank;
	} bank_regs_t;

endpackage

FILE: rtl/cmbc_rom_map.sv
// rom address mapper: bank selection, bank-zero fixup and bank count wrap
// depends on cmbc_pkg
module cmbc_rom_map #(
	parameter int ROM_BANKS_MAX = cmbc_pkg::ROM_BANKS_MAX_DEF
) (
	input  cmbc_pkg::bank_regs_t regs,
	input  logic [15:0]          address,
	output logic [22:0]          rom_address
);
	import cmbc_pkg::*;

	localparam logic [8:0] MAX_MASK = 9'(ROM_BANKS_MAX - 1);

	logic [8:0]  raw_bank;
	logic        use_map;
	logic [8:0]  mapped;
	logic [10:0] rem0;
	logic [10:0] rem1;
	logic [10:0] rem2;
	logic [10:0] rem3;
	logic [10:0] cnt;
	logic        odd_count;
	logic [9:0]  wrap_mask;
	logic [8:0]  final_bank;

	// bank number before wrap
	always_comb begin
		raw_bank = '0;
		use_map  = 1'b1;
		if (!address[14]) begin
			use_map = 1'b0;
			if (regs.kind == KIND_MBC1 && regs.bank_mode && regs.bank_count > 10'd32) begin
				raw_bank = {2'b0, regs.high_bank[1:0], 5'b0};
				use_map  = 1'b1;
			end
		end else begin
			unique case (regs.kind)
				KIND_MBC1: begin
					raw_bank = {2'b0, regs.high_bank[1:0], regs.low_bank[4:0]};
					if (regs.low_bank[4:0] == 5'd0) raw_bank[0] = 1'b1;
				end
				KIND_MBC2: begin
					raw_bank = {5'b0, regs.low_bank[3:0]};
					if (regs.low_bank[3:0] == 4'd0) raw_bank = 9'd1;
				end
				KIND_MBC3: begin
					raw_bank = {2'b0, regs.low_bank[6:0]};
					if (regs.low_bank[6:0] == 7'd0) raw_bank = 9'd1;
				end
				default: raw_bank = regs.wide_bank;
			endcase
		end
	end

	// wrap to the bank count: modulo by restoring subtraction for 72, 80, 96
	always_comb begin
		cnt       = {1'b0, regs.bank_count};
		odd_count = regs.bank_count == 10'd72 || regs.bank_count == 10'd80 ||
		            regs.bank_count == 10'd96;
		rem0      = {2'b0, raw_bank};
		rem1      = (rem0 >= (cnt << 2)) ? rem0 - (cnt << 2) : rem0;
		rem2      = (rem1 >= (cnt << 1)) ? rem1 - (cnt << 1) : rem1;
		rem3      = (rem2 >= cnt) ? rem2 - cnt : rem2;
		wrap_mask = regs.bank_count - 10'd1;
		mapped    = odd_count ? rem3[8:0] : (raw_bank & wrap_mask[8:0]);
		final_bank = use_map ? (mapped & MAX_MASK) : 9'd0;
	end

	// byte address
	always_comb begin
		if (regs.kind == KIND_NONE)
			rom_address = {8'b0, address[14:0]};
		else
			rom_address = {final_bank, address[13:0]};
	end

endmodule

FILE: rtl/cartridge_memory_bank_controller_top.sv
// cartridge memory bank controller top level: bank registers, clock, rams
// depends on cmbc_pkg and cmbc_rom_map
//
//  channel  direction  handshake           word
//  req      in         req_valid/req_stall req (action, address, data, ticks)
//  rsp      out        rsp_valid/rsp_stall rsp (source, read data, rom address)
//  cfg      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one word per cycle while req_stall is low: a word is taken, the cart or nibble ram
// is read in the same edge, and its data moves on into the response register when the
// response is not stalled, so a new word may be taken before the last one is out.
// after reset a clearing pass zeroes both rams, with req_stall high; configuration
// writes are taken throughout.
// a stalled response holds the two-stage pipe; req_stall rises when it is full and during the clearing pass.
module cartridge_memory_bank_controller_top #(
	parameter int CART_RAM_BYTES    = cmbc_pkg::CART_RAM_BYTES_DEF,
	parameter int CYCLES_PER_SECOND = cmbc_pkg::CYCLES_PER_SECOND_DEF,
	parameter int ROM_BANKS_MAX     = cmbc_pkg::ROM_BANKS_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cmbc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cmbc_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [17:0]    cfg_data
);
	import cmbc_pkg::*;

	localparam int AW = $clog2(CART_RAM_BYTES);
	localparam int DW = $clog2(CYCLES_PER_SECOND);
	localparam logic [AW-1:0] CLR_LAST = AW'(CART_RAM_BYTES - 1);
	localparam logic [17:0]   RAM_LIMIT = 18'(CART_RAM_BYTES);
	localparam logic [DW:0]   CPS = (DW + 1)'(CYCLES_PER_SECOND);

	// configuration
	logic [2:0]  mapper_kind_q;
	logic [9:0]  rom_bank_count_q;
	logic [17:0] ram_size_q;

	// bank and clock state
	logic        ram_enable_q;
	logic [7:0]  low_bank_q;
	logic [7:0]  high_bank_q;
	logic        bank_mode_q;
	logic [8:0]  wide_bank_q;
	logic [7:0]  live_q [5];
	logic [7:0]  latched_q [5];
	logic        latch_valid_q;
	logic        latch_armed_q;
	logic        halted_q;
	logic [DW-1:0] divider_q;

	// memories
	logic [7:0]  cart_mem [CART_RAM_BYTES];
	logic [3:0]  nib_mem [NIBBLE_RAM_DEPTH];
	logic [7:0]  cart_rd_q;
	logic [3:0]  nib_rd_q;

	// clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	// pipeline
	logic  s1_valid_q;
	rsp_t  s1_q;
	logic  s1_cart_q;
	logic  s1_nib_q;
	logic  out_valid_q;
	rsp_t  out_q;

	logic        accept;
	logic        s1_move;
	logic [2:0]  kind;
	logic        clk_sel;
	logic [2:0]  clk_r;
	logic [3:0]  ram_bank;
	logic [16:0] ram_off;
	logic        ram_ok;
	logic        area_rom;
	logic        area_ext;
	bank_regs_t  bank_regs;
	logic [22:0] mapped_addr;
	rsp_t        s1_next;
	logic        rd_cart;
	logic        rd_nib;
	logic        wr_cart;
	logic        wr_nib;
	logic [DW:0] div_sum;
	logic        sec_carry;
	logic [7:0]  adv [5];
	logic [8:0]  day_next;
	logic [7:0]  v;

	// handshakes
	assign cfg_ready = 1'b1;
	assign s1_move   = !out_valid_q || !rsp_stall;
	assign req_stall = clr_busy_q || (s1_valid_q && !s1_move);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign v         = req.write_data;

	// decode
	always_comb begin
		kind     = (mapper_kind_q > KIND_MBC5) ? KIND_NONE : mapper_kind_q;
		clk_sel  = kind == KIND_MBC3 && high_bank_q >= 8'h08 && high_bank_q <= 8'h0C;
		clk_r    = high_bank_q[2:0];
		area_rom = !req.address[15];
		area_ext = req.address[15:13] == 3'b101;
		ram_bank = '0;
		unique case (kind)
			KIND_MBC1: ram_bank = bank_mode_q ? {2'b0, high_bank_q[1:0]} : 4'd0;
			KIND_MBC3: ram_bank = {2'b0, high_bank_q[1:0]};
			KIND_MBC5: ram_bank = high_bank_q[3:0];
			default:   ram_bank = 4'd0;
		endcase
		ram_off = {ram_bank, req.address[12:0]};
		ram_ok  = ram_enable_q && ram_size_q != 18'd0 &&
		          {1'b0, ram_off} < ram_size_q && {1'b0, ram_off} < RAM_LIMIT;
	end

	assign bank_regs = '{kind: kind, bank_count: rom_bank_count_q, low_bank: low_bank_q,
	                     high_bank: high_bank_q, bank_mode: bank_mode_q,
	                     wide_bank: wide_bank_q};

	cmbc_rom_map #(
		.ROM_BANKS_MAX(ROM_BANKS_MAX)
	) u_rom_map (
		.regs       (bank_regs),
		.address    (req.address),
		.rom_address(mapped_addr)
	);

	// memory access enables
	always_comb begin
		rd_cart = 1'b0;
		rd_nib  = 1'b0;
		wr_cart = 1'b0;
		wr_nib  = 1'b0;
		if (accept && area_ext && !clk_sel) begin
			if (kind == KIND_MBC2) begin
				rd_nib = req.action == ACT_READ;
				wr_nib = req.action == ACT_WRITE && ram_enable_q;
			end else if (ram_ok) begin
				rd_cart = req.action == ACT_READ;
				wr_cart = req.action == ACT_WRITE;
			end
		end
	end

	// first stage result
	always_comb begin
		s1_next = '{data_source: SRC_NONE, read_data: 8'd0, rom_address: 23'd0};
		if (req.action == ACT_READ) begin
			if (area_rom) begin
				s1_next.data_source = SRC_ROM;
				s1_next.rom_address = mapped_addr;
			end else if (area_ext) begin
				s1_next.data_source = SRC_DATA;
				if (clk_sel)
					s1_next.read_data = latch_valid_q ? latched_q[clk_r] : live_q[clk_r];
				else if (kind != KIND_MBC2 && !ram_ok)
					s1_next.read_data = 8'hFF;
			end
		end
	end

	// clock second divider and rollover
	always_comb begin
		div_sum   = {1'b0, divider_q} + (DW + 1)'(req.tick_cycles);
		sec_carry = div_sum >= CPS;
		for (int i = 0; i < 5; i++) adv[i] = live_q[i];
		day_next  = {live_q[4][0], live_q[3]} + 9'd1;
		if (live_q[0] != 8'd59) begin
			adv[0] = {2'b0, 6'(live_q[0][5:0] + 6'd1)};
		end else begin
			adv[0] = 8'd0;
			if (live_q[1] != 8'd59) begin
				adv[1] = {2'b0, 6'(live_q[1][5:0] + 6'd1)};
			end else begin
				adv[1] = 8'd0;
				if (live_q[2] != 8'd23) begin
					adv[2] = {3'b0, 5'(live_q[2][4:0] + 5'd1)};
				end else begin
					adv[2] = 8'd0;
					adv[3] = day_next[7:0];
					adv[4] = {live_q[4][7:1], day_next[8]};
					if ({live_q[4][0], live_q[3]} == 9'h1FF) adv[4][7] = 1'b1;
				end
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_kind_q    <= KIND_NONE;
			rom_bank_count_q <= 10'd2;
			ram_size_q       <= 18'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAPPER_KIND:    mapper_kind_q    <= cfg_data[2:0];
				CFG_ROM_BANK_COUNT: rom_bank_count_q <= cfg_data[9:0];
				CFG_RAM_SIZE_BYTES: ram_size_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// bank registers, clock and latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enable_q  <= 1'b0;
			low_bank_q    <= 8'd1;
			high_bank_q   <= 8'd0;
			bank_mode_q   <= 1'b0;
			wide_bank_q   <= 9'd1;
			latch_valid_q <= 1'b0;
			latch_armed_q <= 1'b0;
			halted_q      <= 1'b0;
			divider_q     <= '0;
			for (int i = 0; i < 5; i++) begin
				live_q[i]    <= 8'd0;
				latched_q[i] <= 8'd0;
			end
		end else if (accept && req.action == ACT_TICK) begin
			if (!halted_q) begin
				if (sec_carry) begin
					divider_q <= DW'(div_sum - CPS);
					for (int i = 0; i < 5; i++) live_q[i] <= adv[i];
				end else begin
					divider_q <= div_sum[DW-1:0];
				end
			end
		end else if (accept && req.action == ACT_WRITE) begin
			unique case (req.address[15:13])
				3'd0: begin
					if (kind != KIND_MBC2 || !req.address[8])
						ram_enable_q <= v[3:0] == 4'hA;
				end
				3'd1: begin
					if (kind == KIND_MBC2) begin
						if (req.address[8]) low_bank_q <= {4'b0, v[3:0]};
					end else if (kind == KIND_MBC5) begin
						if (!req.address[12]) wide_bank_q <= {wide_bank_q[8], v};
						else                  wide_bank_q <= {v[0], wide_bank_q[7:0]};
					end else begin
						low_bank_q <= v;
					end
				end
				3'd2: high_bank_q <= (kind == KIND_MBC5) ? {4'b0, v[3:0]} : v;
				3'd3: begin
					if (kind == KIND_MBC1) begin
						bank_mode_q <= v[0];
					end else if (kind == KIND_MBC3) begin
						if (v == 8'd0) begin
							latch_armed_q <= 1'b1;
						end else if (v == 8'd1 && latch_armed_q) begin
							for (int i = 0; i < 5; i++) latched_q[i] <= live_q[i];
							latch_valid_q <= 1'b1;
							latch_armed_q <= 1'b0;
						end
					end
				end
				3'd5: begin
					if (clk_sel) begin
						unique case (clk_r)
							3'd4: begin
								live_q[4] <= v & 8'hC1;
								halted_q  <= v[6];
							end
							3'd3:    live_q[3] <= v;
							3'd2:    live_q[2] <= v & 8'h1F;
							3'd1:    live_q[1] <= v & 8'h3F;
							default: live_q[0] <= v & 8'h3F;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == CLR_LAST) clr_busy_q <= 1'b0;
		end
	end

	// cart ram
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			cart_mem[clr_idx_q] <= 8'd0;
		else if (wr_cart)
			cart_mem[ram_off[AW-1:0]] <= v;
		if (rd_cart)
			cart_rd_q <= cart_mem[ram_off[AW-1:0]];
	end

	// nibble ram
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			nib_mem[clr_idx_q[NIB_AW-1:0]] <= 4'd0;
		else if (wr_nib)
			nib_mem[req.address[NIB_AW-1:0]] <= v[3:0];
		if (rd_nib)
			nib_rd_q <= nib_mem[req.address[NIB_AW-1:0]];
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_move) out_valid_q <= s1_valid_q;
			if (accept)       s1_valid_q <= 1'b1;
			else if (s1_move) s1_valid_q <= 1'b0;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q      <= s1_next;
			s1_cart_q <= rd_cart;
			s1_nib_q  <= rd_nib;
		end
		if (s1_move && s1_valid_q) begin
			out_q.data_source <= s1_q.data_source;
			out_q.rom_address <= s1_q.rom_address;
			if (s1_cart_q)     out_q.read_data <= cart_rd_q;
			else if (s1_nib_q) out_q.read_data <= {4'hF, nib_rd_q};
			else               out_q.read_data <= s1_q.read_data;
		end
	end

endmodule
